>>> sv/uer_pkg.sv
package uer_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_TRIGGER_WIDTH    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ROUNDTRIP    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SENSOR_DELAY = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMER_OVERHEAD   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_POLL_PERIOD      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOUND_SPEED      = 3'd5;

    localparam logic [7:0]  TRIGGER_WIDTH_RST    = 8'd10;
    localparam logic [15:0] MAX_ROUNDTRIP_RST    = 16'd23200;
    localparam logic [15:0] MAX_SENSOR_DELAY_RST = 16'd5800;
    localparam logic [7:0]  TIMER_OVERHEAD_RST   = 8'd24;
    localparam logic [7:0]  POLL_PERIOD_RST      = 8'd24;
    localparam logic [9:0]  SOUND_SPEED_RST      = 10'd343;

    localparam int TIME_BITS_DEFAULT = 16;

    // Phase counter spans the whole start window (roundtrip + sensor delay).
    localparam int PHASE_TIMER_W = 17;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_WAIT,
        PH_MEAS
    } phase_t;

    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_OK       = 3'd1,
        ST_BUSY     = 3'd2,
        ST_START_TO = 3'd3,
        ST_ECHO_TO  = 3'd4
    } status_t;

    typedef struct packed {
        logic start_request;
        logic echo_level;
    } in_word_t;

    typedef struct packed {
        logic        trigger_level;
        logic        busy_res;
        logic        done_res;
        logic [2:0]  status;
        logic        echo_valid;
        logic [15:0] duration_us;
        logic [24:0] distance_um;
    } out_word_t;

endpackage

>>> sv/ultrasonic_echo_ranger.sv
// Channel  | Dir | Handshake              | Word
// ---------+-----+------------------------+--------------------------------------------
// in       | in  | in_valid / in_ready    | in_word_t: start_request, echo_level
// out      | out | out_valid / out_ready  | out_word_t: trigger, busy, done, status, ...
// cfg      | in  | cfg_we (no wait)       | cfg_index selects register, cfg_data value
//
// One word in, one word out. Each word is one microsecond tick of the sensor pins.
// Registered in order: an input register, then the ranging state machine updates and
// loads the result register; one word is taken every cycle when out_ready stays high.
// The distance product (half duration times sound speed) is formed from the result
// register, so the 15x10 multiplier sits alone after the last register.
// Reset clears the state machine, status and both stages' valid bits; configuration
// returns to its defaults. A stall on out holds both stages and drops in_ready once full.
module ultrasonic_echo_ranger #(
    parameter int TIME_BITS = uer_pkg::TIME_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  uer_pkg::in_word_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output uer_pkg::out_word_t                  out_data,
    input  logic                                cfg_we,
    input  logic [uer_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import uer_pkg::*;

    // Duration saturates at the narrower of TIME_BITS and the 16-bit field.
    localparam int LIM_BITS = (TIME_BITS < 16) ? TIME_BITS : 16;
    localparam logic [PHASE_TIMER_W-1:0] DUR_LIM = PHASE_TIMER_W'((1 << LIM_BITS) - 1);

    // Configuration registers
    logic [7:0]  trigger_width_reg;
    logic [15:0] max_roundtrip_reg;
    logic [15:0] max_sensor_delay_reg;
    logic [7:0]  timer_overhead_reg;
    logic [7:0]  poll_period_reg;
    logic [9:0]  sound_speed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_width_reg    <= TRIGGER_WIDTH_RST;
            max_roundtrip_reg    <= MAX_ROUNDTRIP_RST;
            max_sensor_delay_reg <= MAX_SENSOR_DELAY_RST;
            timer_overhead_reg   <= TIMER_OVERHEAD_RST;
            poll_period_reg      <= POLL_PERIOD_RST;
            sound_speed_reg      <= SOUND_SPEED_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TRIGGER_WIDTH:    trigger_width_reg    <= cfg_data[7:0];
                CFG_MAX_ROUNDTRIP:    max_roundtrip_reg    <= cfg_data;
                CFG_MAX_SENSOR_DELAY: max_sensor_delay_reg <= cfg_data;
                CFG_TIMER_OVERHEAD:   timer_overhead_reg   <= cfg_data[7:0];
                CFG_POLL_PERIOD:      poll_period_reg      <= cfg_data[7:0];
                CFG_SOUND_SPEED:      sound_speed_reg      <= cfg_data[9:0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // Input register stage
    logic     in_valid_reg;
    in_word_t in_word_reg;
    logic     advance;

    assign advance  = in_valid_reg && (!out_valid || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_word_reg <= in_data;
        end
    end

    // Ranging state
    phase_t                   phase_reg, phase_next;
    logic [PHASE_TIMER_W-1:0] phase_timer_reg, phase_timer_next;
    logic [7:0]               poll_timer_reg, poll_timer_next;
    logic [15:0]              last_duration_reg, last_duration_next;
    status_t                  last_status_reg, last_status_next;
    logic                     echo_ok_reg, echo_ok_next;
    logic                     trig, done;

    logic [PHASE_TIMER_W-1:0] elapsed;
    logic [PHASE_TIMER_W-1:0] start_window;
    logic [8:0]               poll_count;
    logic [PHASE_TIMER_W-1:0] dur_raw;
    logic [PHASE_TIMER_W-1:0] dur_sat;

    assign elapsed      = phase_timer_reg + PHASE_TIMER_W'(1);
    assign start_window = PHASE_TIMER_W'(max_roundtrip_reg) + PHASE_TIMER_W'(max_sensor_delay_reg);
    assign poll_count   = {1'b0, poll_timer_reg} + 9'd1;

    // Elapsed minus overhead, floored at zero, then clamped.
    always_comb
    begin
        if (elapsed > PHASE_TIMER_W'(timer_overhead_reg))
        begin
            dur_raw = elapsed - PHASE_TIMER_W'(timer_overhead_reg);
        end
        else
        begin
            dur_raw = '0;
        end
        dur_sat = (dur_raw > DUR_LIM) ? DUR_LIM : dur_raw;
    end

    always_comb
    begin
        phase_next         = phase_reg;
        phase_timer_next   = phase_timer_reg;
        poll_timer_next    = poll_timer_reg;
        last_duration_next = last_duration_reg;
        last_status_next   = last_status_reg;
        echo_ok_next       = echo_ok_reg;
        trig               = 1'b0;
        done               = 1'b0;

        if (in_word_reg.start_request)
        begin
            // Restart the ping, cancelling whatever was running.
            phase_next       = PH_TRIG;
            phase_timer_next = PHASE_TIMER_W'(1);
            poll_timer_next  = '0;
            last_status_next = ST_NONE;
            echo_ok_next     = 1'b0;
            trig             = 1'b1;
        end
        else
        begin
            unique case (phase_reg)
                PH_TRIG:
                begin
                    if (phase_timer_reg < PHASE_TIMER_W'(trigger_width_reg))
                    begin
                        phase_timer_next = elapsed;
                        trig             = 1'b1;
                    end
                    else if (in_word_reg.echo_level)
                    begin
                        // Echo already high as the trigger drops: sensor busy.
                        phase_next       = PH_IDLE;
                        last_status_next = ST_BUSY;
                        done             = 1'b1;
                    end
                    else
                    begin
                        phase_next       = PH_WAIT;
                        phase_timer_next = '0;
                    end
                end
                PH_WAIT:
                begin
                    if (in_word_reg.echo_level)
                    begin
                        phase_next       = PH_MEAS;
                        phase_timer_next = '0;
                        poll_timer_next  = '0;
                    end
                    else if (elapsed > start_window)
                    begin
                        phase_next       = PH_IDLE;
                        last_status_next = ST_START_TO;
                        done             = 1'b1;
                    end
                    else
                    begin
                        phase_timer_next = elapsed;
                    end
                end
                PH_MEAS:
                begin
                    phase_timer_next = elapsed;
                    if (poll_count >= {1'b0, poll_period_reg})
                    begin
                        // Poll tick: sample echo and check the timeout.
                        poll_timer_next = '0;
                        if (elapsed > PHASE_TIMER_W'(max_roundtrip_reg))
                        begin
                            phase_next       = PH_IDLE;
                            last_status_next = ST_ECHO_TO;
                            echo_ok_next     = 1'b0;
                            done             = 1'b1;
                        end
                        else if (!in_word_reg.echo_level)
                        begin
                            phase_next         = PH_IDLE;
                            last_duration_next = dur_sat[15:0];
                            last_status_next   = ST_OK;
                            echo_ok_next       = 1'b1;
                            done               = 1'b1;
                        end
                    end
                    else
                    begin
                        poll_timer_next = poll_count[7:0];
                    end
                end
                default: ;  // idle: hold
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            phase_timer_reg   <= '0;
            poll_timer_reg    <= '0;
            last_duration_reg <= '0;
            last_status_reg   <= ST_NONE;
            echo_ok_reg       <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg         <= phase_next;
            phase_timer_reg   <= phase_timer_next;
            poll_timer_reg    <= poll_timer_next;
            last_duration_reg <= last_duration_next;
            last_status_reg   <= last_status_next;
            echo_ok_reg       <= echo_ok_next;
        end
    end

    // Result register
    logic        out_valid_reg;
    logic        trigger_out_reg;
    logic        busy_out_reg;
    logic        done_out_reg;
    status_t     status_out_reg;
    logic        echo_valid_out_reg;
    logic [15:0] duration_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            trigger_out_reg    <= trig;
            busy_out_reg       <= (phase_next != PH_IDLE);
            done_out_reg       <= done;
            status_out_reg     <= last_status_next;
            echo_valid_out_reg <= echo_ok_next;
            duration_out_reg   <= last_duration_next;
        end
    end

    // Distance in micrometres: floor(duration / 2) * speed, zero without a valid echo.
    logic [24:0] distance;

    always_comb
    begin
        if (echo_valid_out_reg)
        begin
            distance = duration_out_reg[15:1] * sound_speed_reg;
        end
        else
        begin
            distance = '0;
        end
    end

    assign out_valid              = out_valid_reg;
    assign out_data.trigger_level = trigger_out_reg;
    assign out_data.busy_res      = busy_out_reg;
    assign out_data.done_res      = done_out_reg;
    assign out_data.status        = status_out_reg;
    assign out_data.echo_valid    = echo_valid_out_reg;
    assign out_data.duration_us   = duration_out_reg;
    assign out_data.distance_um   = distance;

    // A finished ping is never still busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.done_res |-> !out_data.busy_res)
        else $error("done word reports busy");

    // A valid echo always carries the ok status.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.echo_valid |-> out_data.status == ST_OK)
        else $error("echo_valid without ok status");

    // The trigger only runs while a ping is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.trigger_level |-> out_data.busy_res)
        else $error("trigger high while idle");

    // A word waiting in the input stage is never lost under a stall.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input stage dropped a word");

endmodule
